>>> rtl/divisor_count_by_spf_sieve_defines.svh
// Assertion macros for the divisor count block.
`ifndef DIVISOR_COUNT_BY_SPF_SIEVE_DEFINES_SVH
`define DIVISOR_COUNT_BY_SPF_SIEVE_DEFINES_SVH
`ifndef SYNTH
`define DCS_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DCS_ASSERT_NEXT(label, clk, rst_n, cond, nxt, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) else $error(msg);
`else
`define DCS_ASSERT(label, clk, rst_n, prop, msg)
`define DCS_ASSERT_NEXT(label, clk, rst_n, cond, nxt, msg)
`endif
`endif

>>> rtl/dcs_pkg.sv
// Shared types and constants for the divisor count block.
`default_nettype none
package dcs_pkg;
	localparam int unsigned QW = 16;
	localparam int unsigned CW = 10;
	typedef logic [QW-1:0] query_t;
	typedef logic [CW-1:0] count_t;
	// queue entry from front to back
	typedef struct packed {
		logic   err;
		query_t value;
	} job_t;
endpackage
`default_nettype wire

>>> rtl/dcs_front.sv
// Front end: accepts query words, screens range, holds a one-entry queue.
`default_nettype none
module dcs_front import dcs_pkg::*; #(
	parameter int unsigned MAX_VALUE = 65535
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   start,
	input  wire query_t query_value,
	output logic        busy,
	output logic        job_valid,
	output job_t        job,
	input  wire logic   job_take
);
	logic full_q;
	job_t job_q;
	logic above;

	// compare against the table top in a 24-bit width
	assign above = ({8'd0, query_value} > 24'(MAX_VALUE));
	assign busy = full_q;
	assign job_valid = full_q;
	assign job = job_q;

	// load the queue slot on accept, free it when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (start && !full_q) begin
			full_q <= 1'b1;
		end else if (job_take) begin
			full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !full_q) begin
			job_q.value <= query_value;
			job_q.err   <= (query_value == '0) || above;
		end
	end
endmodule
`default_nettype wire

>>> rtl/dcs_back.sv
// Back end: builds the factor table by linear sieve, then factors queries.
`default_nettype none
module dcs_back import dcs_pkg::*; #(
	parameter int unsigned MAX_VALUE = 65535
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   job_valid,
	input  wire job_t   job,
	output logic        job_take,
	output logic        done,
	output count_t      divisor_count
);
`include "divisor_count_by_spf_sieve_defines.svh"
	localparam int unsigned TW = (MAX_VALUE < 65536) ? 16 : $clog2(MAX_VALUE + 1);
	localparam int unsigned TD = MAX_VALUE + 1;
	localparam int unsigned PD = MAX_VALUE / 2 + 8;
	localparam int unsigned PW = $clog2(PD + 1);
	localparam logic [TW-1:0] TOP = TW'(MAX_VALUE);

	localparam logic [3:0] S_CLR   = 4'd0;
	localparam logic [3:0] S_IRD   = 4'd1;
	localparam logic [3:0] S_IWT   = 4'd2;
	localparam logic [3:0] S_JRD   = 4'd3;
	localparam logic [3:0] S_JWT   = 4'd4;
	localparam logic [3:0] S_JCHK  = 4'd5;
	localparam logic [3:0] S_JMOD  = 4'd6;
	localparam logic [3:0] S_IDLE  = 4'd7;
	localparam logic [3:0] S_QRD   = 4'd8;
	localparam logic [3:0] S_QWT   = 4'd9;
	localparam logic [3:0] S_QDIV  = 4'd10;
	localparam logic [3:0] S_QMUL  = 4'd11;
	localparam logic [3:0] S_OUT   = 4'd12;

	logic [TW-1:0] spf_mem [TD];
	logic [TW-1:0] prm_mem [PD];
	logic [3:0]    state_q;
	logic [TW:0]   i_q;
	logic [PW-1:0] j_q, ptot_q;
	logic [TW-1:0] p_q, f_q, n_q, rd_q, prd_q;
	logic [2*TW-1:0] m_q;
	logic [TW-1:0] quo_q, rem_q;
	logic [TW-1:0] dn_q;
	logic [4:0]    bit_q;
	logic [4:0]    e_q;
	count_t        res_q;
	logic          mode_q, prod_q, rd_en, wr_en;
	logic [TW-1:0] rd_addr, wr_addr, wr_data;
	logic [TW:0]   trial;

	// table port: one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (wr_en) spf_mem[wr_addr] <= wr_data;
		if (rd_en) rd_q <= spf_mem[rd_addr];
		prd_q <= prm_mem[j_q[PW-1:0] < PW'(PD) ? j_q : '0];
		if (state_q == S_IWT && rd_q == '0 && ptot_q < PW'(PD))
			prm_mem[ptot_q] <= i_q[TW-1:0];
	end

	// restoring division, one quotient bit per cycle
	assign trial = {rem_q, dn_q[TW-1]} - {1'b0, mode_q ? p_q : f_q};

	always_comb begin
		rd_en = 1'b0;
		rd_addr = i_q[TW-1:0];
		wr_en = 1'b0;
		wr_addr = i_q[TW-1:0];
		wr_data = '0;
		job_take = 1'b0;
		unique case (state_q)
			S_CLR: begin
				wr_en = 1'b1;
			end
			S_IRD: rd_en = 1'b1;
			S_IWT: begin
				wr_en = (rd_q == '0);
				wr_data = i_q[TW-1:0];
			end
			S_JCHK: begin
				wr_en = (m_q <= (2*TW)'(TOP)) && (j_q < ptot_q);
				wr_addr = m_q[TW-1:0];
				wr_data = p_q;
			end
			S_IDLE: job_take = job_valid;
			S_QRD: begin
				rd_en = 1'b1;
				rd_addr = n_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			i_q <= '0;
			ptot_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				// zero the table, then sweep i upward
				S_CLR: begin
					if (i_q[TW-1:0] == TOP) begin
						i_q <= (TW+1)'(2);
						state_q <= S_IRD;
					end else i_q <= i_q + 1'b1;
				end
				S_IRD: state_q <= S_IWT;
				S_IWT: begin
					if (rd_q == '0 && ptot_q < PW'(PD)) ptot_q <= ptot_q + 1'b1;
					j_q <= '0;
					state_q <= S_JRD;
				end
				S_JRD: state_q <= S_JWT;
				S_JWT: begin
					p_q <= prd_q;
					state_q <= S_JMOD;
					m_q <= '0;
					mode_q <= 1'b1;
				end
				S_JMOD: begin
					m_q <= (2*TW)'(i_q[TW-1:0]) * (2*TW)'(p_q);
					state_q <= S_JCHK;
				end
				S_JCHK: begin
					if (j_q >= ptot_q || m_q > (2*TW)'(TOP)) begin
						if (i_q[TW-1:0] == TOP) state_q <= S_IDLE;
						else begin
							i_q <= i_q + 1'b1;
							state_q <= S_IRD;
						end
					end else begin
						dn_q <= i_q[TW-1:0];
						rem_q <= '0;
						bit_q <= 5'(TW);
						state_q <= S_QDIV;
					end
				end
				S_IDLE: begin
					if (job_valid) begin
						n_q <= job.value;
						res_q <= count_t'(1);
						e_q <= '0;
						f_q <= '0;
						mode_q <= 1'b0;
						state_q <= job.err ? S_OUT : S_QRD;
						if (job.err) res_q <= '0;
					end
				end
				S_QRD: state_q <= (n_q > TW'(1)) ? S_QWT : S_QMUL;
				S_QWT: begin
					if (rd_q == f_q && f_q >= TW'(2)) begin
						dn_q <= n_q;
						rem_q <= '0;
						bit_q <= 5'(TW);
						e_q <= e_q + 1'b1;
						state_q <= S_QDIV;
					end else begin
						prod_q <= (rd_q >= TW'(2));
						state_q <= S_QMUL;
						f_q <= rd_q;
					end
				end
				S_QDIV: begin
					if (!trial[TW]) rem_q <= trial[TW-1:0];
					else rem_q <= {rem_q[TW-2:0], dn_q[TW-1]};
					dn_q <= {dn_q[TW-2:0], ~trial[TW]};
					bit_q <= bit_q - 1'b1;
					if (bit_q == 5'd1) begin
						if (mode_q) begin
							// i % p == 0 ends the inner loop
							if ((!trial[TW] ? trial[TW-1:0]
								: {rem_q[TW-2:0], dn_q[TW-1]}) == '0) begin
								if (i_q[TW-1:0] == TOP) state_q <= S_IDLE;
								else begin
									i_q <= i_q + 1'b1;
									state_q <= S_IRD;
								end
							end else begin
								j_q <= j_q + 1'b1;
								state_q <= S_JRD;
							end
						end else begin
							n_q <= {dn_q[TW-2:0], ~trial[TW]};
							state_q <= S_QRD;
						end
					end
				end
				S_QMUL: begin
					// fold in the finished exponent
					if (e_q != '0)
						res_q <= CW'(res_q * (CW'(e_q) + CW'(1)));
					e_q <= '0;
					if (n_q > TW'(1) && prod_q && f_q != rd_q) begin
						state_q <= S_QRD;
						prod_q <= 1'b0;
					end else if (n_q > TW'(1) && prod_q) begin
						e_q <= '0;
						state_q <= S_QWT;
					end else state_q <= S_OUT;
				end
				S_OUT: begin
					done <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign divisor_count = res_q;

	`DCS_ASSERT_NEXT(a_take_idle, clk, arst_n, job_take, state_q != S_IDLE, "take left idle")
	`DCS_ASSERT(a_done_one, clk, arst_n, done |=> !done, "double done")
	`DCS_ASSERT_NEXT(a_out_done, clk, arst_n, state_q == S_OUT, done, "no done")
endmodule
`default_nettype wire

>>> rtl/divisor_count_by_spf_sieve.sv
// Top level of the divisor count block.
//  channel  | ports                      | handshake
//  query    | start, busy, query_value   | accept when start && !busy
//  result   | done, divisor_count        | one-cycle strobe, no stall
// After reset the table is cleared, then the sieve sweeps each value upward through its
// inner steps, each with a bit-serial division; queries wait in the queue until it ends.
// A query then does a table read, a compare and a division for each prime factor counted
// with multiplicity, a multiply for each distinct prime, and a final report.
// Reset clears all control state; the receiver cannot stall.
`default_nettype none
module divisor_count_by_spf_sieve import dcs_pkg::*; #(
	parameter int unsigned MAX_VALUE = 65535
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   start,
	input  wire query_t query_value,
	output logic        busy,
	output logic        done,
	output count_t      divisor_count
);
	logic job_valid, job_take;
	job_t job;

	dcs_front #(.MAX_VALUE(MAX_VALUE)) u_front (
		.clk, .arst_n, .start, .query_value, .busy,
		.job_valid, .job, .job_take
	);
	dcs_back #(.MAX_VALUE(MAX_VALUE)) u_back (
		.clk, .arst_n, .job_valid, .job, .job_take, .done, .divisor_count
	);
endmodule
`default_nettype wire
